// ----- hdl/assert_macros.svh -----
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check prop at every rising edge while reset is released.
`define ASSERT_RST(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("assertion failed");

// Check prop at every rising edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("assertion failed");

`endif

// ----- hdl/sed_pkg.sv -----
package sed_pkg;

    localparam int CHAR_W         = 8;
    localparam int STATUS_W       = 3;
    localparam int HEX_CNT_W      = 4;
    localparam int MAX_HEX_DIGITS = 8;

    localparam logic [HEX_CNT_W-1:0] HEX_CNT_ZERO = '0;
    localparam logic [HEX_CNT_W-1:0] HEX_CNT_MAX  = HEX_CNT_W'(MAX_HEX_DIGITS);
    localparam logic [HEX_CNT_W-1:0] HEX_CNT_OVER = HEX_CNT_W'(MAX_HEX_DIGITS + 1);
    localparam logic [HEX_CNT_W-1:0] HEX_BAD      = '1;

    // Result queue
    localparam int Q_DEPTH = 4;
    localparam int Q_IDX_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_BYTE     = 3'd0;
    localparam logic [STATUS_W-1:0] ST_END      = 3'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_ESC  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_BAD_OPEN = 3'd3;
    localparam logic [STATUS_W-1:0] ST_UNTERM   = 3'd4;
    localparam logic [STATUS_W-1:0] ST_BAD_NUM  = 3'd5;

    // Characters
    localparam logic [CHAR_W-1:0] CH_BSLASH = 8'h5C;
    localparam logic [CHAR_W-1:0] CH_N      = 8'h6E;
    localparam logic [CHAR_W-1:0] CH_ZERO   = 8'h30;
    localparam logic [CHAR_W-1:0] CH_T      = 8'h74;
    localparam logic [CHAR_W-1:0] CH_DQUOTE = 8'h22;
    localparam logic [CHAR_W-1:0] CH_SQUOTE = 8'h27;
    localparam logic [CHAR_W-1:0] CH_U      = 8'h75;
    localparam logic [CHAR_W-1:0] CH_LBRACE = 8'h7B;
    localparam logic [CHAR_W-1:0] CH_RBRACE = 8'h7D;
    localparam logic [CHAR_W-1:0] CH_LF     = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_NUL    = 8'h00;
    localparam logic [CHAR_W-1:0] CH_TAB    = 8'h09;

    typedef enum logic [3:0] {
        MODE_NORMAL = 4'b0001,
        MODE_ESC    = 4'b0010,
        MODE_UOPEN  = 4'b0100,
        MODE_HEX    = 4'b1000
    } t_mode;

    typedef struct packed {
        logic [CHAR_W-1:0]   out_char;
        logic [STATUS_W-1:0] status;
        logic                run_end;
    } t_result;

    // Returns {is_hex, nibble}.
    function automatic logic [4:0] hex_digit(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] d;
        begin
            d = '0;
            hex_digit = '0;
            if (c inside {[8'h30:8'h39]}) begin
                d = c - 8'h30;
                hex_digit = {1'b1, d[3:0]};
            end else if (c inside {[8'h61:8'h66]}) begin
                d = c - 8'h57;
                hex_digit = {1'b1, d[3:0]};
            end else if (c inside {[8'h41:8'h46]}) begin
                d = c - 8'h37;
                hex_digit = {1'b1, d[3:0]};
            end
        end
    endfunction

endpackage

// ----- hdl/sed_in_if.sv -----
interface sed_in_if
    import sed_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] char_in;
    logic              is_final;

    modport source (output valid, output char_in, output is_final, input ready);
    modport sink   (input valid, input char_in, input is_final, output ready);
endinterface

// ----- hdl/sed_out_if.sv -----
interface sed_out_if
    import sed_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [CHAR_W-1:0]   out_char;
    logic [STATUS_W-1:0] status;
    logic                run_end;

    modport source (output valid, output out_char, output status, output run_end,
                    input ready);
    modport sink   (input valid, input out_char, input status, input run_end,
                    output ready);
endinterface

// ----- hdl/string_escape_decoder.sv -----
// String literal escape decoder. Feed the body of a literal one byte per
// transaction on i_in, with is_final set on its last byte. Every byte
// lands in an input register, is decoded against the escape state once the
// result queue has room for two results, and its results enter a four-entry
// result queue that drives o_out. Sustained rate is one byte per cycle as
// long as o_out is drained; a final byte that is itself a plain byte or
// completes an escape yields two results (the byte, then the end marker),
// which leave o_out one after the other. Results: status 0 carries a
// decoded byte in out_char; status 1 is the end of the literal; statuses
// 2..5 are errors (bad escape, bad unicode open, unterminated unicode, bad
// unicode number). End and error results carry out_char 0 and run_end 1.
// After an error all bytes up to and including the final one are dropped
// without a result. A u{...} escape takes 1 to 8 hex digits and emits the
// low byte of the value.
`include "assert_macros.svh"

module string_escape_decoder
    import sed_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    sed_in_if.sink    i_in,
    sed_out_if.source o_out
);

    // ---------------------------------------------------------------
    // Input register
    // ---------------------------------------------------------------
    logic              r_in_valid;
    logic [CHAR_W-1:0] r_in_char;
    logic              r_in_fin;

    // ---------------------------------------------------------------
    // Decode state
    // ---------------------------------------------------------------
    t_mode                r_mode,    n_mode;
    logic [CHAR_W-1:0]    r_hex_val, n_hex_val;  // only the low byte is ever emitted
    logic [HEX_CNT_W-1:0] r_hex_cnt, n_hex_cnt;
    logic                 r_drain,   n_drain;

    // ---------------------------------------------------------------
    // Result queue (shift queue, head at entry 0)
    // ---------------------------------------------------------------
    t_result              r_q [Q_DEPTH];
    t_result              n_q [Q_DEPTH];
    logic [Q_CNT_W-1:0]   r_cnt, n_cnt;

    logic    room;      // queue can take the two results an item may produce
    logic    fire;      // decode the registered byte this cycle
    logic    pop;
    logic    push0, push1;
    t_result res0, res1;

    logic                is_err;
    logic [STATUS_W-1:0] err_code;
    logic                have_byte;
    logic [CHAR_W-1:0]   byte_val;
    logic                do_clear;
    logic [4:0]          hd;

    assign room  = (r_cnt <= Q_CNT_W'(Q_DEPTH - 2));
    assign fire  = r_in_valid && room;
    assign pop   = o_out.valid && o_out.ready;

    // Accept a new transaction whenever the input register is empty or drains now.
    assign i_in.ready = !r_in_valid || room;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_char <= i_in.char_in;
            r_in_fin  <= i_in.is_final;
        end
    end

    // ---------------------------------------------------------------
    // Decode: one step of the escape state machine
    // ---------------------------------------------------------------
    always_comb begin
        n_mode    = r_mode;
        n_hex_val = r_hex_val;
        n_hex_cnt = r_hex_cnt;
        n_drain   = r_drain;
        is_err    = 1'b0;
        err_code  = ST_BAD_ESC;
        have_byte = 1'b0;
        byte_val  = '0;
        do_clear  = 1'b0;
        push0     = 1'b0;
        push1     = 1'b0;
        res0      = '{out_char: '0, status: ST_END, run_end: 1'b1};
        res1      = '{out_char: '0, status: ST_END, run_end: 1'b1};
        hd        = hex_digit(r_in_char);

        if (r_drain) begin
            // Drop everything up to the final byte of the failed literal.
            if (r_in_fin) begin
                n_drain  = 1'b0;
                do_clear = 1'b1;
            end
        end else begin
            case (r_mode)
                MODE_ESC: begin
                    n_mode    = MODE_NORMAL;
                    have_byte = 1'b1;
                    case (r_in_char)
                        CH_N:      byte_val = CH_LF;
                        CH_ZERO:   byte_val = CH_NUL;
                        CH_BSLASH: byte_val = CH_BSLASH;
                        CH_T:      byte_val = CH_TAB;
                        CH_DQUOTE: byte_val = CH_DQUOTE;
                        CH_SQUOTE: byte_val = CH_SQUOTE;
                        CH_U: begin
                            have_byte = 1'b0;
                            if (r_in_fin) begin
                                is_err   = 1'b1;
                                err_code = ST_BAD_OPEN;
                            end else begin
                                n_mode = MODE_UOPEN;
                            end
                        end
                        default: begin
                            have_byte = 1'b0;
                            is_err    = 1'b1;
                            err_code  = ST_BAD_ESC;
                        end
                    endcase
                end
                MODE_UOPEN: begin
                    if (r_in_char != CH_LBRACE) begin
                        is_err   = 1'b1;
                        err_code = ST_BAD_OPEN;
                    end else if (r_in_fin) begin
                        is_err   = 1'b1;
                        err_code = ST_UNTERM;
                    end else begin
                        n_mode    = MODE_HEX;
                        n_hex_val = '0;
                        n_hex_cnt = HEX_CNT_ZERO;
                    end
                end
                MODE_HEX: begin
                    if (r_in_char == CH_RBRACE) begin
                        if (r_hex_cnt == HEX_CNT_ZERO || r_hex_cnt > HEX_CNT_MAX) begin
                            is_err   = 1'b1;
                            err_code = ST_BAD_NUM;
                        end else begin
                            have_byte = 1'b1;
                            byte_val  = r_hex_val;
                            n_mode    = MODE_NORMAL;
                        end
                    end else if (r_in_fin) begin
                        is_err   = 1'b1;
                        err_code = ST_UNTERM;
                    end else if (!hd[4]) begin
                        n_hex_cnt = HEX_BAD;
                    end else if (r_hex_cnt < HEX_CNT_MAX) begin
                        n_hex_val = {r_hex_val[CHAR_W-5:0], hd[3:0]};
                        n_hex_cnt = r_hex_cnt + HEX_CNT_W'(1);
                    end else if (r_hex_cnt == HEX_CNT_MAX) begin
                        n_hex_cnt = HEX_CNT_OVER;
                    end
                end
                default: begin
                    n_mode = MODE_NORMAL;
                    if (r_in_char == CH_BSLASH) begin
                        if (r_in_fin) begin
                            is_err   = 1'b1;
                            err_code = ST_BAD_ESC;
                        end else begin
                            n_mode = MODE_ESC;
                        end
                    end else begin
                        have_byte = 1'b1;
                        byte_val  = r_in_char;
                    end
                end
            endcase

            if (is_err) begin
                // An error ends the literal's output; drain the rest of it.
                push0    = 1'b1;
                res0     = '{out_char: '0, status: err_code, run_end: 1'b1};
                do_clear = 1'b1;
                n_drain  = !r_in_fin;
            end else if (have_byte) begin
                push0 = 1'b1;
                res0  = '{out_char: byte_val, status: ST_BYTE, run_end: 1'b0};
                push1 = r_in_fin;
                do_clear = r_in_fin;
            end else if (r_in_fin) begin
                push0    = 1'b1;
                do_clear = 1'b1;
            end
        end

        if (do_clear) begin
            n_mode    = MODE_NORMAL;
            n_hex_val = '0;
            n_hex_cnt = HEX_CNT_ZERO;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= MODE_NORMAL;
            r_hex_val <= '0;
            r_hex_cnt <= HEX_CNT_ZERO;
            r_drain   <= 1'b0;
        end else if (fire) begin
            r_mode    <= n_mode;
            r_hex_val <= n_hex_val;
            r_hex_cnt <= n_hex_cnt;
            r_drain   <= n_drain;
        end
    end

    // ---------------------------------------------------------------
    // Result queue: pop the head, then append up to two results
    // ---------------------------------------------------------------
    always_comb begin
        n_q   = r_q;
        n_cnt = r_cnt;
        if (pop) begin
            for (int i = 0; i < Q_DEPTH - 1; i++) begin
                n_q[i] = r_q[i + 1];
            end
            n_cnt = n_cnt - Q_CNT_W'(1);
        end
        if (fire && push0) begin
            n_q[n_cnt[Q_IDX_W-1:0]] = res0;
            n_cnt = n_cnt + Q_CNT_W'(1);
        end
        if (fire && push1) begin
            n_q[n_cnt[Q_IDX_W-1:0]] = res1;
            n_cnt = n_cnt + Q_CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q <= n_q;
    end

    assign o_out.valid    = (r_cnt != '0);
    assign o_out.out_char = r_q[0].out_char;
    assign o_out.status   = r_q[0].status;
    assign o_out.run_end  = r_q[0].run_end;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    `ASSERT_RST(a_q_bound, i_clk, i_rst_n, r_cnt <= Q_CNT_W'(Q_DEPTH))
    `ASSERT_RST(a_drain_clears_mode, i_clk, i_rst_n, r_drain |-> (r_mode == MODE_NORMAL))
    `ASSERT_RST(a_end_has_no_char, i_clk, i_rst_n,
                (o_out.valid && o_out.run_end) |-> (o_out.out_char == '0))
    `ASSERT_RST(a_only_bytes_open, i_clk, i_rst_n,
                (o_out.valid && !o_out.run_end) |-> (o_out.status == ST_BYTE))

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 1ps

import sed_pkg::*;

// Hex digit bounds not covered by the package character set.
localparam logic [CHAR_W-1:0] CH_NINE = 8'h39;
localparam logic [CHAR_W-1:0] CH_LC_A = 8'h61;
localparam logic [CHAR_W-1:0] CH_LC_F = 8'h66;
localparam logic [CHAR_W-1:0] CH_UC_A = 8'h41;
localparam logic [CHAR_W-1:0] CH_UC_F = 8'h46;

typedef logic [CHAR_W-1:0] t_text[$];

// Return {is_digit, value} for one byte of a unicode escape.
function automatic logic [4:0] hex_nibble(input logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] off;
    off = '0;
    if (c >= CH_ZERO && c <= CH_NINE) begin
        off = c - CH_ZERO;
        return {1'b1, off[3:0]};
    end
    if (c >= CH_LC_A && c <= CH_LC_F) begin
        off = c - CH_LC_A + 8'd10;
        return {1'b1, off[3:0]};
    end
    if (c >= CH_UC_A && c <= CH_UC_F) begin
        off = c - CH_UC_A + 8'd10;
        return {1'b1, off[3:0]};
    end
    return 5'b0;
endfunction

// Track the escape state of the literal and queue the decoded results.
class escape_scoreboard;
    t_result              pending_results[$];
    t_mode                mode;
    logic [31:0]          hex_val;
    logic [HEX_CNT_W-1:0] hex_cnt;
    bit                   draining;
    int unsigned          errors;
    int unsigned          live_bytes;

    function new();
        clear_run();
        draining   = 1'b0;
        errors     = 0;
        live_bytes = 0;
    endfunction

    function void clear_run();
        mode    = MODE_NORMAL;
        hex_val = '0;
        hex_cnt = HEX_CNT_ZERO;
    endfunction

    function void note_byte(input logic [CHAR_W-1:0] c, input logic fin);
        logic [4:0]          dig;
        logic [CHAR_W-1:0]   val;
        logic [STATUS_W-1:0] fault;
        bit                  have_byte;
        bit                  failed;
        have_byte = 1'b0;
        failed    = 1'b0;
        val       = CH_NUL;
        fault     = ST_BYTE;
        // Drop everything after an error up to the end of the literal.
        if (draining) begin
            if (fin) begin
                draining = 1'b0;
                clear_run();
            end
            return;
        end
        live_bytes++;
        case (mode)
            MODE_ESC: begin
                mode      = MODE_NORMAL;
                have_byte = 1'b1;
                case (c)
                    CH_N:      val = CH_LF;
                    CH_ZERO:   val = CH_NUL;
                    CH_BSLASH: val = CH_BSLASH;
                    CH_T:      val = CH_TAB;
                    CH_DQUOTE: val = CH_DQUOTE;
                    CH_SQUOTE: val = CH_SQUOTE;
                    CH_U: begin
                        have_byte = 1'b0;
                        if (fin) begin
                            failed = 1'b1;
                            fault  = ST_BAD_OPEN;
                        end else begin
                            mode = MODE_UOPEN;
                        end
                    end
                    default: begin
                        have_byte = 1'b0;
                        failed    = 1'b1;
                        fault     = ST_BAD_ESC;
                    end
                endcase
            end
            MODE_UOPEN: begin
                if (c != CH_LBRACE) begin
                    failed = 1'b1;
                    fault  = ST_BAD_OPEN;
                end else if (fin) begin
                    failed = 1'b1;
                    fault  = ST_UNTERM;
                end else begin
                    mode    = MODE_HEX;
                    hex_val = '0;
                    hex_cnt = HEX_CNT_ZERO;
                end
            end
            MODE_HEX: begin
                if (c == CH_RBRACE) begin
                    if (hex_cnt == HEX_CNT_ZERO || hex_cnt > HEX_CNT_MAX) begin
                        failed = 1'b1;
                        fault  = ST_BAD_NUM;
                    end else begin
                        have_byte = 1'b1;
                        val       = hex_val[7:0];
                        mode      = MODE_NORMAL;
                    end
                end else if (fin) begin
                    failed = 1'b1;
                    fault  = ST_UNTERM;
                end else begin
                    dig = hex_nibble(c);
                    if (!dig[4]) begin
                        hex_cnt = HEX_BAD;
                    end else if (hex_cnt < HEX_CNT_MAX) begin
                        hex_val = {hex_val[27:0], dig[3:0]};
                        hex_cnt = hex_cnt + HEX_CNT_W'(1);
                    end else if (hex_cnt == HEX_CNT_MAX) begin
                        hex_cnt = HEX_CNT_OVER;
                    end
                end
            end
            default: begin
                mode = MODE_NORMAL;
                if (c == CH_BSLASH) begin
                    if (fin) begin
                        failed = 1'b1;
                        fault  = ST_BAD_ESC;
                    end else begin
                        mode = MODE_ESC;
                    end
                end else begin
                    have_byte = 1'b1;
                    val       = c;
                end
            end
        endcase
        if (failed) begin
            pending_results.push_back('{CH_NUL, fault, 1'b1});
            clear_run();
            if (!fin) draining = 1'b1;
            return;
        end
        if (have_byte) pending_results.push_back('{val, ST_BYTE, 1'b0});
        if (fin) begin
            pending_results.push_back('{CH_NUL, ST_END, 1'b1});
            clear_run();
        end
    endfunction

    function void check_result(input t_result got);
        t_result want;
        if (pending_results.size() == 0) begin
            $error("unexpected result: out_char %h status %0d run_end %0d",
                   got.out_char, got.status, got.run_end);
            errors++;
            return;
        end
        want = pending_results.pop_front();
        if (got.out_char !== want.out_char) begin
            $error("out_char mismatch: expected %h, actual %h", want.out_char, got.out_char);
            errors++;
        end
        if (got.status !== want.status) begin
            $error("status mismatch: expected %0d, actual %0d", want.status, got.status);
            errors++;
        end
        if (got.run_end !== want.run_end) begin
            $error("run_end mismatch: expected %0d, actual %0d", want.run_end, got.run_end);
            errors++;
        end
    endfunction
endclass

module testbench;

    localparam int unsigned LIVE_TARGET = 800;   // non-dropped bytes to send
    localparam int unsigned MAX_GAP     = 14;
    localparam int unsigned IDLE_LIMIT  = 2000;  // cycles with no transaction
    localparam int unsigned TAIL_CYCLES = 16;    // settle time after the last result

    logic i_clk;
    logic i_rst_n;

    sed_in_if  byte_if ();
    sed_out_if result_if ();

    string_escape_decoder u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (byte_if),
        .o_out   (result_if)
    );

    escape_scoreboard sb;
    bit               src_burst;   // sender runs without gaps while set
    bit               snk_burst;   // receiver never stalls while set
    int unsigned      idle_cycles;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Literal generation
    // ------------------------------------------------------------------

    // Draw a hex digit, upper or lower case.
    function automatic logic [CHAR_W-1:0] rand_hex_char();
        logic [CHAR_W-1:0] n;
        n = CHAR_W'($urandom_range(0, 15));
        if (n < 10) return CH_ZERO + n;
        return ($urandom_range(0, 1) ? CH_UC_A : CH_LC_A) + n - 8'd10;
    endfunction

    // Draw a byte that breaks a hex run without closing it.
    function automatic logic [CHAR_W-1:0] rand_non_hex_char();
        logic [CHAR_W-1:0] c;
        do c = CHAR_W'($urandom_range(0, 255));
        while (hex_nibble(c) != 5'b0 || c == CH_RBRACE);
        return c;
    endfunction

    function automatic void put_hex(ref t_text txt, input int unsigned n);
        repeat (n) txt.push_back(rand_hex_char());
    endfunction

    function automatic void put_unicode_open(ref t_text txt);
        txt.push_back(CH_BSLASH);
        txt.push_back(CH_U);
        txt.push_back(CH_LBRACE);
    endfunction

    // Append one well-formed piece: a plain byte, a simple escape or u{hex}.
    function automatic void put_good_piece(ref t_text txt);
        logic [CHAR_W-1:0] c;
        logic [CHAR_W-1:0] simple[6];
        simple = '{CH_N, CH_ZERO, CH_BSLASH, CH_T, CH_DQUOTE, CH_SQUOTE};
        case ($urandom_range(0, 5))
            4: begin
                txt.push_back(CH_BSLASH);
                txt.push_back(simple[3'($urandom_range(0, 5))]);
            end
            5: begin
                put_unicode_open(txt);
                put_hex(txt, $urandom_range(1, MAX_HEX_DIGITS));
                txt.push_back(CH_RBRACE);
            end
            default: begin
                do c = CHAR_W'($urandom_range(0, 255));
                while (c == CH_BSLASH);
                txt.push_back(c);
            end
        endcase
    endfunction

    // Append one broken piece; return 1 when it must be the end of the literal.
    function automatic bit put_bad_piece(ref t_text txt);
        logic [CHAR_W-1:0] c;
        case ($urandom_range(0, 7))
            0: begin   // unknown escape letter
                do c = CHAR_W'($urandom_range(0, 255));
                while (c inside {CH_N, CH_ZERO, CH_BSLASH, CH_T, CH_DQUOTE, CH_SQUOTE, CH_U});
                txt.push_back(CH_BSLASH);
                txt.push_back(c);
            end
            1: begin   // u without an opening brace
                do c = CHAR_W'($urandom_range(0, 255));
                while (c == CH_LBRACE);
                txt.push_back(CH_BSLASH);
                txt.push_back(CH_U);
                txt.push_back(c);
            end
            2: begin   // non-hex byte inside the braces
                put_unicode_open(txt);
                put_hex(txt, $urandom_range(0, 3));
                txt.push_back(rand_non_hex_char());
                put_hex(txt, $urandom_range(0, 2));
                txt.push_back(CH_RBRACE);
            end
            3: begin   // too many digits
                put_unicode_open(txt);
                put_hex(txt, $urandom_range(MAX_HEX_DIGITS + 1, MAX_HEX_DIGITS + 3));
                txt.push_back(CH_RBRACE);
            end
            4: begin   // empty braces
                put_unicode_open(txt);
                txt.push_back(CH_RBRACE);
            end
            5: begin   // hex run cut off by the end of the literal
                put_unicode_open(txt);
                repeat ($urandom_range(0, 10))
                    txt.push_back($urandom_range(0, 3) == 0 ? rand_non_hex_char()
                                                           : rand_hex_char());
                return 1'b1;
            end
            6: begin   // trailing backslash
                txt.push_back(CH_BSLASH);
                return 1'b1;
            end
            default: begin   // trailing u
                txt.push_back(CH_BSLASH);
                txt.push_back(CH_U);
                return 1'b1;
            end
        endcase
        return 1'b0;
    endfunction

    // Build a literal: mostly well-formed, one in five broken at a random
    // position and, unless that piece must end it, followed by up to three bytes the block must drop.
    function automatic t_text compose_literal();
        t_text       txt;
        int unsigned pieces;
        int unsigned broken_at;
        pieces    = $urandom_range(1, 6);
        broken_at = ($urandom_range(0, 4) == 0) ? $urandom_range(0, pieces - 1) : pieces;
        for (int unsigned i = 0; i < pieces; i++) begin
            if (i == broken_at) begin
                if (!put_bad_piece(txt))
                    repeat ($urandom_range(0, 3))
                        txt.push_back(CHAR_W'($urandom_range(0, 255)));
                break;
            end
            put_good_piece(txt);
        end
        return txt;
    endfunction

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    // Offer one byte; call at a falling edge, return at the falling edge
    // after its transaction. Leave valid high so back-to-back bytes flow.
    task automatic push_byte(input logic [CHAR_W-1:0] c, input logic fin);
        int unsigned gap;
        gap = src_burst ? 0 : $urandom_range(0, MAX_GAP);
        if (gap != 0) begin
            byte_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        byte_if.valid    <= 1'b1;
        byte_if.char_in  <= c;
        byte_if.is_final <= fin;
        do @(posedge i_clk); while (!byte_if.ready);
        @(negedge i_clk);
    endtask

    task automatic send_literal(input t_text txt);
        for (int unsigned i = 0; i < txt.size(); i++)
            push_byte(txt[i], i == txt.size() - 1);
    endtask

    task automatic send_text(input string s);
        t_text txt;
        for (int i = 0; i < s.len(); i++) txt.push_back(s[i]);
        send_literal(txt);
    endtask

    // Hold the sender until every queued result has come out.
    task automatic hold_until_drained();
        byte_if.valid <= 1'b0;
        do @(negedge i_clk); while (sb.pending_results.size() != 0);
    endtask

    // Receiver: stall a random number of cycles before each result, but never while snk_burst is set.
    initial begin
        int unsigned gap;
        result_if.ready = 1'b0;
        snk_burst       = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if ($urandom_range(0, 39) == 0) snk_burst = !snk_burst;
            gap = snk_burst ? 0 : $urandom_range(0, MAX_GAP);
            if (gap != 0) begin
                result_if.ready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            result_if.ready <= 1'b1;
            do @(posedge i_clk); while (!(result_if.valid && result_if.ready));
        end
    end

    // ------------------------------------------------------------------
    // Monitor: predict on every accepted byte, check every accepted result,
    // and stop the run if the interface goes quiet for too long.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        bit moved;
        moved = 1'b0;
        if (i_rst_n) begin
            if (byte_if.valid && byte_if.ready) begin
                sb.note_byte(byte_if.char_in, byte_if.is_final);
                moved = 1'b1;
            end
            if (result_if.valid && result_if.ready) begin
                sb.check_result('{result_if.out_char, result_if.status, result_if.run_end});
                moved = 1'b1;
            end
            idle_cycles = moved ? 0 : idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("FAIL string_escape_decoder");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        sb               = new();
        idle_cycles      = 0;
        src_burst        = 1'b0;
        i_rst_n          = 1'b0;
        byte_if.valid    = 1'b0;
        byte_if.char_in  = '0;
        byte_if.is_final = 1'b0;

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: byte extremes, every simple escape, a mixed-case unicode
        // escape, then each error path.
        send_literal('{CH_NUL, 8'hFF});
        send_text("\\n\\0\\\\\\t\\\"\\'");
        send_text("\\u{1aF}");
        send_text("\\q");               // bad escape on the last byte
        send_text("\\");                // backslash as the last byte
        send_text("\\u");               // u as the last byte
        send_text("\\ux!z");            // u without a brace, then dropped bytes
        send_text("\\u{g");             // cut off after a bad digit
        send_text("\\u{}x\\");          // empty braces, drop a backslash too
        send_text("\\u{123456789}");    // one digit too many
        send_literal('{CH_BSLASH, CH_U, CH_LBRACE, CH_NUL, CH_RBRACE});  // zero in a hex run
        hold_until_drained();

        // Random literals until enough bytes reached the decoder.
        while (sb.live_bytes < LIVE_TARGET) begin
            if ($urandom_range(0, 9) == 0) src_burst = !src_burst;
            if ($urandom_range(0, 49) == 0) hold_until_drained();
            send_literal(compose_literal());
        end

        // Drain, then give the block time to emit anything unexpected.
        hold_until_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (sb.errors == 0)
            $display("PASS string_escape_decoder");
        else
            $display("FAIL string_escape_decoder");
        $finish;
    end

endmodule
